// ===== design/step_counter_extender_macros.svh =====
// ----------------------------------------------------------------------------
// Step counter extender assertion macros
// Shared concurrent assertion forms for the step counter extender.
// ----------------------------------------------------------------------------
`ifndef STEP_COUNTER_EXTENDER_MACROS_SVH
`define STEP_COUNTER_EXTENDER_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SCE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SCE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/sce_pkg.sv =====
// ----------------------------------------------------------------------------
// Step counter extender package
// Types, codes and constants shared by the step counter extender modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sce_pkg;

    // Field widths.
    localparam int RAW_W    = 16;
    localparam int TOTAL_W  = 32;
    localparam int TIME_W   = 32;
    localparam int TALLY_W  = 32;
    localparam int RUN_W    = 8;
    localparam int DELTA_W  = RAW_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Wrap window and register reset values.
    localparam logic [RAW_W-1:0] WRAP_HIGH_FLOOR = 16'hF000;
    localparam logic [RAW_W-1:0] WRAP_LOW_CEIL   = 16'h0FFF;
    localparam logic [RAW_W-1:0] MAX_DELTA_RESET = 16'd100;
    localparam logic [RUN_W-1:0] THRESHOLD_RESET = 8'd3;

    // Reported status codes.
    typedef enum logic [1:0] {
        ST_SEARCHING = 2'd0,
        ST_READY     = 2'd1,
        ST_ERROR     = 2'd2
    } status_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_DELTA       = 2'd0,
        CFG_ERROR_THRESHOLD = 2'd1
    } cfg_index_t;

    // Configuration register values.
    typedef struct packed {
        logic [RAW_W-1:0] max_delta;
        logic [RUN_W-1:0] error_threshold;
    } cfg_t;

    // One sample request.
    typedef struct packed {
        logic              read_ok;
        logic [RAW_W-1:0]  raw_count;
        logic [TIME_W-1:0] now_ms;
    } sample_t;

    // One result request.
    typedef struct packed {
        logic               accepted;
        logic [TOTAL_W-1:0] total_steps;
        logic [RAW_W-1:0]   last_raw;
        logic [TALLY_W-1:0] error_count;
        status_t            status;
        logic [TIME_W-1:0]  last_update_ms;
    } result_t;

endpackage

`default_nettype wire

// ===== design/sce_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Step counter extender configuration registers
// Holds the delta limit and the error threshold written over the config port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sce_cfg_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [sce_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sce_pkg::CFG_DATA_W-1:0] cfg_data,
    output sce_pkg::cfg_t                       cfg
);

    sce_pkg::cfg_t cfg_reg;
    sce_pkg::cfg_t cfg_next;

    // Writes are always taken.
    assign cfg_ready = 1'b1;
    assign cfg        = cfg_reg;

    // Register decode; writes to unknown indexes are dropped.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (sce_pkg::cfg_index_t'(cfg_index))
                sce_pkg::CFG_MAX_DELTA:
                begin
                    cfg_next.max_delta = cfg_data[sce_pkg::RAW_W-1:0];
                end
                sce_pkg::CFG_ERROR_THRESHOLD:
                begin
                    cfg_next.error_threshold = cfg_data[sce_pkg::RUN_W-1:0];
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_delta       <= sce_pkg::MAX_DELTA_RESET;
            cfg_reg.error_threshold <= sce_pkg::THRESHOLD_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/sce_core.sv =====
// ----------------------------------------------------------------------------
// Step counter extender core
// Tracker state and the single-pass update logic for one sample.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sce_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             fire,
    input  sce_pkg::sample_t      sample,
    input  sce_pkg::cfg_t         cfg,
    output sce_pkg::result_t      result
);

    // Tracker state.
    logic                           started_reg;
    logic                           started_next;
    logic [sce_pkg::RAW_W-1:0]      prev_raw_reg;
    logic [sce_pkg::RAW_W-1:0]      prev_raw_next;
    logic [sce_pkg::TOTAL_W-1:0]    total_reg;
    logic [sce_pkg::TOTAL_W-1:0]    total_next;
    logic [sce_pkg::RUN_W-1:0]      fail_run_reg;
    logic [sce_pkg::RUN_W-1:0]      fail_run_next;
    logic [sce_pkg::TALLY_W-1:0]    tally_reg;
    logic [sce_pkg::TALLY_W-1:0]    tally_next;
    sce_pkg::status_t               status_reg;
    sce_pkg::status_t               status_next;
    logic [sce_pkg::RAW_W-1:0]      shown_raw_reg;
    logic [sce_pkg::RAW_W-1:0]      shown_raw_next;
    logic [sce_pkg::TIME_W-1:0]     update_time_reg;
    logic [sce_pkg::TIME_W-1:0]     update_time_next;

    // Datapath intermediates.
    logic [sce_pkg::DELTA_W-1:0]    delta;
    logic [sce_pkg::TOTAL_W:0]      sum;
    logic [sce_pkg::TOTAL_W-1:0]    sat_total;
    logic                           delta_ok;
    logic [sce_pkg::RUN_W-1:0]      run_inc;
    logic                           acc;

    // Delta across a rise, a 16-bit wrap, or a sensor reset.
    always_comb
    begin
        if (sample.raw_count >= prev_raw_reg)
        begin
            delta = {1'b0, sample.raw_count - prev_raw_reg};
        end
        else if (prev_raw_reg >= sce_pkg::WRAP_HIGH_FLOOR
                 && sample.raw_count <= sce_pkg::WRAP_LOW_CEIL)
        begin
            delta = {1'b1, {sce_pkg::RAW_W{1'b0}}} - {1'b0, prev_raw_reg}
                    + {1'b0, sample.raw_count};
        end
        else
        begin
            delta = {1'b0, sample.raw_count};
        end
    end

    // Limit check and saturating add.
    assign delta_ok  = delta <= {1'b0, cfg.max_delta};
    assign sum       = {1'b0, total_reg}
                       + {{(sce_pkg::TOTAL_W + 1 - sce_pkg::DELTA_W){1'b0}}, delta};
    assign sat_total = sum[sce_pkg::TOTAL_W] ? {sce_pkg::TOTAL_W{1'b1}}
                                             : sum[sce_pkg::TOTAL_W-1:0];

    // The failure run saturates at its all-ones value.
    assign run_inc = (&fail_run_reg) ? fail_run_reg : fail_run_reg + 1'b1;

    // Next state for one sample.
    always_comb
    begin
        started_next     = started_reg;
        prev_raw_next    = prev_raw_reg;
        total_next       = total_reg;
        fail_run_next    = fail_run_reg;
        tally_next       = tally_reg;
        status_next      = status_reg;
        shown_raw_next   = shown_raw_reg;
        update_time_next = update_time_reg;
        acc              = 1'b0;

        if (sample.read_ok)
        begin
            fail_run_next  = '0;
            status_next    = sce_pkg::ST_READY;
            shown_raw_next = sample.raw_count;
            prev_raw_next  = sample.raw_count;
            started_next   = 1'b1;
            if (!started_reg)
            begin
                // First good sample loads the total directly.
                total_next = {{(sce_pkg::TOTAL_W - sce_pkg::RAW_W){1'b0}}, sample.raw_count};
                acc        = 1'b1;
            end
            else if (delta_ok)
            begin
                total_next = sat_total;
                acc        = 1'b1;
            end
            if (acc)
            begin
                update_time_next = sample.now_ms;
            end
            else
            begin
                tally_next = tally_reg + 1'b1;
            end
        end
        else
        begin
            fail_run_next = run_inc;
            tally_next    = tally_reg + 1'b1;
            if (run_inc >= cfg.error_threshold)
            begin
                status_next = sce_pkg::ST_ERROR;
            end
        end
    end

    // Result reflects the state after this sample.
    always_comb
    begin
        result.accepted       = acc;
        result.total_steps    = total_next;
        result.last_raw       = shown_raw_next;
        result.error_count    = tally_next;
        result.status         = status_next;
        result.last_update_ms = update_time_next;
    end

    // State registers, updated once per issued sample.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg     <= 1'b0;
            prev_raw_reg    <= '0;
            total_reg       <= '0;
            fail_run_reg    <= '0;
            tally_reg       <= '0;
            status_reg      <= sce_pkg::ST_SEARCHING;
            shown_raw_reg   <= '0;
            update_time_reg <= '0;
        end
        else if (fire)
        begin
            started_reg     <= started_next;
            prev_raw_reg    <= prev_raw_next;
            total_reg       <= total_next;
            fail_run_reg    <= fail_run_next;
            tally_reg       <= tally_next;
            status_reg      <= status_next;
            shown_raw_reg   <= shown_raw_next;
            update_time_reg <= update_time_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/step_counter_extender.sv =====
// ----------------------------------------------------------------------------
// Step counter extender
// Extends a 16-bit raw step count into a saturating 32-bit total and keeps
// read error statistics, one result per sample.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake             Payload
//  in       input      in_valid / in_stall   read_ok, raw_count, now_ms
//  out      output     out_valid / out_stall accepted, total_steps, last_raw,
//                                            error_count, status, last_update_ms
//  cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
//  A sample passes from the input register through the core update into the
//  result register. One sample is taken per cycle while the output is not
//  stalled, set by the core update and the tracker state loop.
//  Reset clears the tracker state and loads the register defaults.
//  A stalled output holds its result and backs up into the input register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "step_counter_extender_macros.svh"

module step_counter_extender (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // Sample channel.
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic                           read_ok,
    input  wire logic [sce_pkg::RAW_W-1:0]      raw_count,
    input  wire logic [sce_pkg::TIME_W-1:0]     now_ms,
    // Result channel.
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic                                accepted,
    output logic [sce_pkg::TOTAL_W-1:0]         total_steps,
    output logic [sce_pkg::RAW_W-1:0]           last_raw,
    output logic [sce_pkg::TALLY_W-1:0]         error_count,
    output logic [1:0]                          status,
    output logic [sce_pkg::TIME_W-1:0]          last_update_ms,
    // Configuration write channel.
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [sce_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sce_pkg::CFG_DATA_W-1:0] cfg_data
);

    sce_pkg::cfg_t    cfg;
    sce_pkg::sample_t in_item_reg;
    logic             in_valid_reg;
    logic             in_valid_next;
    sce_pkg::result_t core_result;
    sce_pkg::result_t out_item_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             advance;
    logic             in_take;

    // Configuration registers.
    sce_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Handshake: the held sample moves on when the result slot is free.
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    // Input register.
    always_comb
    begin
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg.read_ok   <= read_ok;
            in_item_reg.raw_count <= raw_count;
            in_item_reg.now_ms    <= now_ms;
        end
    end

    // Tracker state and update logic.
    sce_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .sample (in_item_reg),
        .cfg    (cfg),
        .result (core_result)
    );

    // Result register.
    always_comb
    begin
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg <= core_result;
        end
    end

    // Output ports.
    assign out_valid      = out_valid_reg;
    assign accepted       = out_item_reg.accepted;
    assign total_steps    = out_item_reg.total_steps;
    assign last_raw       = out_item_reg.last_raw;
    assign error_count    = out_item_reg.error_count;
    assign status         = out_item_reg.status;
    assign last_update_ms = out_item_reg.last_update_ms;

    // Checks on the internal pipeline.
    `SCE_ASSERT_NOW(a_stall_needs_held, in_stall, in_valid_reg,
                    "stall with empty input register")
    `SCE_ASSERT_NEXT(a_advance_fills_out, advance, out_valid_reg,
                     "issued sample left no result")
    `SCE_ASSERT_NOW(a_accept_is_ready, out_valid && accepted,
                    status == sce_pkg::ST_READY, "accepted result not in ready status")

endmodule

`default_nettype wire

// ===== sim/step_counter_extender_test.sv =====
// ----------------------------------------------------------------------------
// Step counter extender testbench
// Drives raw step samples through the extender with random gaps and output
// stalls, tracks the 32-bit total, error statistics and status in a local
// model, and checks every result field against it in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module step_counter_extender_test;

    localparam int RAW_W      = sce_pkg::RAW_W;
    localparam int TOTAL_W    = sce_pkg::TOTAL_W;
    localparam int TIME_W     = sce_pkg::TIME_W;
    localparam int TALLY_W    = sce_pkg::TALLY_W;
    localparam int RUN_W      = sce_pkg::RUN_W;
    localparam int CFG_IDX_W  = sce_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = sce_pkg::CFG_DATA_W;

    localparam int unsigned CYCLE_LIMIT   = 600000;
    localparam int unsigned SETTLE_CYCLES = 6;
    localparam int unsigned DRAIN_AT_ITEM = 12;
    localparam int unsigned MAX_REPORTS   = 200;
    // Index outside the register map; a write to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

    // Clock, reset and DUT ports.
    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  in_valid   = 1'b0;
    logic                  in_stall;
    logic                  read_ok    = 1'b0;
    logic [RAW_W-1:0]      raw_count  = '0;
    logic [TIME_W-1:0]     now_ms     = '0;
    logic                  out_valid;
    logic                  out_stall  = 1'b0;
    logic                  accepted;
    logic [TOTAL_W-1:0]    total_steps;
    logic [RAW_W-1:0]      last_raw;
    logic [TALLY_W-1:0]    error_count;
    logic [1:0]            status;
    logic [TIME_W-1:0]     last_update_ms;
    logic                  cfg_valid  = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index  = sce_pkg::CFG_MAX_DELTA;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;

    // Pending sample requests and the results they must produce.
    sce_pkg::sample_t sample_queue[$];
    sce_pkg::result_t expected_results[$];

    // Local copy of the tracker state and its register settings.
    logic               seen_first    = 1'b0;
    logic [RAW_W-1:0]   base_raw      = '0;
    logic [TOTAL_W-1:0] ext_total     = '0;
    logic [RUN_W-1:0]   miss_run      = '0;
    logic [TALLY_W-1:0] fault_count   = '0;
    sce_pkg::status_t   health        = sce_pkg::ST_SEARCHING;
    logic [RAW_W-1:0]   held_raw      = '0;
    logic [TIME_W-1:0]  stamp_ms      = '0;
    logic [RAW_W-1:0]   lim_max_delta = sce_pkg::MAX_DELTA_RESET;
    logic [RUN_W-1:0]   lim_threshold = sce_pkg::THRESHOLD_RESET;

    // Bench control.
    logic               idle_enable   = 1'b1;
    logic               in_fired      = 1'b0;
    logic               draining      = 1'b0;
    logic [RAW_W-1:0]   sensor_raw    = '0;
    int unsigned        gap_left      = 0;
    int unsigned        stall_left    = 0;
    int unsigned        sent_count    = 0;
    int unsigned        cycle_count   = 0;
    int unsigned        fail_count    = 0;

    step_counter_extender dut (.*);

    // 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int unsigned idle_gap();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (!idle_enable || pick < 60)
            return 0;
        else if (pick < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // Advances the local tracker by one sample and returns the result it shows.
    function automatic sce_pkg::result_t track_sample(sce_pkg::sample_t item);
        sce_pkg::result_t res;
        logic [RAW_W:0]   delta;
        logic [TOTAL_W:0] sum;
        logic             took;
        took = 1'b0;
        if (item.read_ok) begin
            if (!seen_first) begin
                // The first good read loads the total directly.
                ext_total  = {{(TOTAL_W-RAW_W){1'b0}}, item.raw_count};
                base_raw   = item.raw_count;
                seen_first = 1'b1;
                took       = 1'b1;
            end
            else begin
                if (item.raw_count >= base_raw)
                    delta = {1'b0, item.raw_count - base_raw};
                else if (base_raw >= sce_pkg::WRAP_HIGH_FLOOR
                         && item.raw_count <= sce_pkg::WRAP_LOW_CEIL)
                    delta = 17'h10000 - {1'b0, base_raw} + {1'b0, item.raw_count};
                else
                    delta = {1'b0, item.raw_count};
                base_raw = item.raw_count;
                if (delta <= {1'b0, lim_max_delta}) begin
                    sum       = {1'b0, ext_total}
                                + {{(TOTAL_W-RAW_W){1'b0}}, delta};
                    ext_total = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
                    took      = 1'b1;
                end
            end
            miss_run = '0;
            health   = sce_pkg::ST_READY;
            held_raw = item.raw_count;
            if (took)
                stamp_ms = item.now_ms;
            else
                fault_count = fault_count + 1'b1;
        end
        else begin
            if (miss_run != '1)
                miss_run = miss_run + 1'b1;
            fault_count = fault_count + 1'b1;
            if (miss_run >= lim_threshold)
                health = sce_pkg::ST_ERROR;
        end
        res.accepted       = took;
        res.total_steps    = ext_total;
        res.last_raw       = held_raw;
        res.error_count    = fault_count;
        res.status         = health;
        res.last_update_ms = stamp_ms;
        return res;
    endfunction

    task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        end
    endtask

    // Input and output monitor, plus the run time limit.
    always @(posedge clk)
    begin
        sce_pkg::result_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("step_counter_extender_test: FAIL");
            $finish;
        end
        else begin
            in_fired = rst_n && in_valid && !in_stall;
            if (in_fired)
                expected_results.push_back(track_sample('{read_ok, raw_count, now_ms}));
            if (rst_n && out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    fail_count++;
                    $error("result with no sample request pending");
                end
                else begin
                    want = expected_results.pop_front();
                    compare_field("accepted", 32'(want.accepted), 32'(accepted));
                    compare_field("total_steps", want.total_steps, total_steps);
                    compare_field("last_raw", 32'(want.last_raw), 32'(last_raw));
                    compare_field("error_count", want.error_count, error_count);
                    compare_field("status", 32'(want.status), 32'(status));
                    compare_field("last_update_ms", want.last_update_ms, last_update_ms);
                end
            end
        end
    end

    // Sample driver: holds a request until taken, then idles or sends the next.
    always @(negedge clk)
    begin
        sce_pkg::sample_t item;
        if (rst_n && (!in_valid || in_fired)) begin
            if (draining && expected_results.size() == 0)
                draining = 1'b0;
            if (draining || gap_left != 0 || sample_queue.size() == 0) begin
                if (!draining && gap_left != 0)
                    gap_left--;
                in_valid <= 1'b0;
            end
            else begin
                item = sample_queue.pop_front();
                read_ok   <= item.read_ok;
                raw_count <= item.raw_count;
                now_ms    <= item.now_ms;
                in_valid  <= 1'b1;
                sent_count++;
                gap_left = idle_gap();
                // Now and then hold off until the block has nothing in flight.
                if (sent_count == DRAIN_AT_ITEM || $urandom_range(0, 63) == 0)
                    draining = 1'b1;
            end
        end
    end

    // Result side back-pressure.
    always @(negedge clk)
    begin
        if (stall_left != 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else begin
            out_stall <= 1'b0;
            if ($urandom_range(0, 2) == 0)
                stall_left = idle_gap();
        end
    end

    task automatic queue_sample(logic ok, logic [RAW_W-1:0] raw, logic [TIME_W-1:0] tick);
        sample_queue.push_back('{ok, raw, tick});
    endtask

    // Register write; only called while no sample is in flight.
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == sce_pkg::CFG_MAX_DELTA)
            lim_max_delta = data;
        else if (idx == sce_pkg::CFG_ERROR_THRESHOLD)
            lim_threshold = data[RUN_W-1:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Waits until every request is taken and every result is back.
    task automatic wait_idle();
        while (sample_queue.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly plausible sensor traffic: small rises, wraps near the top,
    // sensor resets, large jumps and bursts of failed reads.
    task automatic queue_random_samples(int unsigned count);
        int unsigned pick;
        int unsigned burst;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                sensor_raw = sensor_raw + RAW_W'($urandom_range(0, lim_max_delta));
                queue_sample(1'b1, sensor_raw, $urandom);
            end
            else if (pick < 64) begin
                sensor_raw = RAW_W'($urandom);
                queue_sample(1'b1, sensor_raw, $urandom);
            end
            else if (pick < 74) begin
                sensor_raw = RAW_W'($urandom_range(sce_pkg::WRAP_HIGH_FLOOR, 16'hFFFF));
                queue_sample(1'b1, sensor_raw, $urandom);
            end
            else if (pick < 82) begin
                sensor_raw = RAW_W'($urandom_range(0, sce_pkg::WRAP_LOW_CEIL));
                queue_sample(1'b1, sensor_raw, $urandom);
            end
            else begin
                burst = $urandom_range(1, 5);
                repeat (burst) queue_sample(1'b0, RAW_W'($urandom), $urandom);
            end
        end
    endtask

    // Stimulus sequence.
    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed samples at the reset register values.
        queue_sample(1'b0, 16'hFFFF, 32'hFFFF_FFFF);   // failure before any good read
        queue_sample(1'b1, 16'hFFF0, 32'h0000_0000);   // first good read loads the total
        queue_sample(1'b1, 16'hFFFF, 32'h0000_0001);   // small rise
        queue_sample(1'b1, 16'h0005, 32'h5555_5555);   // wrap through zero
        queue_sample(1'b1, 16'h0100, 32'hAAAA_AAAA);   // rise above the limit
        queue_sample(1'b1, 16'h0050, 32'h0000_0004);   // drop outside the wrap window
        queue_sample(1'b1, 16'h0050, 32'h0000_0005);   // no change
        queue_sample(1'b1, 16'h00B4, 32'h0000_0006);   // rise of exactly the limit
        queue_sample(1'b1, 16'h0119, 32'h0000_0007);   // one past the limit
        queue_sample(1'b0, 16'hAAAA, 32'h0000_0008);
        queue_sample(1'b0, 16'h5555, 32'h0000_0009);
        queue_sample(1'b0, 16'h0000, 32'h0000_000A);   // third failure sets error
        queue_sample(1'b1, 16'hEFFF, 32'h0000_000B);   // recovery, large rise
        queue_sample(1'b1, 16'h0000, 32'h0000_000C);   // drop from just below the window
        queue_sample(1'b1, 16'hF000, 32'h0000_000D);
        queue_sample(1'b1, 16'h1000, 32'h0000_000E);   // drop to just above the low window
        queue_sample(1'b1, 16'hF000, 32'h0000_000F);
        queue_sample(1'b1, 16'h0FFF, 32'h0000_0010);   // widest wrap
        queue_sample(1'b1, 16'hFFFF, 32'h0000_0011);
        queue_sample(1'b1, 16'h0000, 32'h0000_0012);   // wrap by one step
        wait_idle();

        // Tightest limit and the lowest normal threshold.
        write_register(sce_pkg::CFG_MAX_DELTA, 16'h0000);
        write_register(sce_pkg::CFG_ERROR_THRESHOLD, 16'h0001);
        queue_random_samples(25);
        wait_idle();

        // Widest limit, highest threshold and a failure run past saturation.
        write_register(sce_pkg::CFG_MAX_DELTA, 16'hFFFF);
        write_register(sce_pkg::CFG_ERROR_THRESHOLD, {8'($urandom), 8'hFF});
        repeat (260) queue_sample(1'b0, RAW_W'($urandom), $urandom);
        queue_random_samples(5);
        wait_idle();

        // Zero threshold: every failed read flags the error status.
        write_register(sce_pkg::CFG_ERROR_THRESHOLD, 16'h0000);
        write_register(sce_pkg::CFG_MAX_DELTA, CFG_DATA_W'($urandom_range(0, 600)));
        write_register(CFG_UNMAPPED, CFG_DATA_W'($urandom));
        queue_random_samples(20);
        wait_idle();

        // Random settings, with some phases run back to back without idling.
        for (int phase = 0; phase < 4; phase++) begin
            idle_enable = phase[0];
            write_register(sce_pkg::CFG_MAX_DELTA,
                           CFG_DATA_W'(($urandom_range(0, 3) == 0) ? $urandom
                                                                   : $urandom_range(0, 2000)));
            write_register(sce_pkg::CFG_ERROR_THRESHOLD, CFG_DATA_W'($urandom));
            queue_random_samples(10);
            wait_idle();
        end

        idle_enable = 1'b1;
        write_register(sce_pkg::CFG_ERROR_THRESHOLD, 16'h0002);
        queue_random_samples(8);
        wait_idle();

        if (fail_count == 0)
            $display("step_counter_extender_test: PASS");
        else
            $display("step_counter_extender_test: FAIL");
        $finish;
    end

endmodule
